FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/itoa_fmt_pkg.sv
`timescale 1ns / 1ps

package itoa_fmt_pkg;

    localparam int VALUE_W    = 32;
    localparam int FWIDTH_W   = 6;
    localparam int CHAR_W     = 7;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int NDIG_W     = 4;
    localparam int BIT_CNT_W  = 5;

    localparam logic [1:0] KIND_SDEC  = 2'd0;
    localparam logic [1:0] KIND_UDEC  = 2'd1;
    localparam logic [1:0] KIND_LHEX  = 2'd2;
    localparam logic [1:0] KIND_UHEX  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CH_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CH_UA    = 7'h41;

    typedef struct packed {
        logic [1:0]          kind;
        logic [VALUE_W-1:0]  value;
        logic [FWIDTH_W-1:0] field_width;
        logic                left_align;
        logic                zero_pad;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              last;
    } t_out_item;

    // ASCII for one digit; upper selects the hex letter case
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d >= 4'd10) begin
            digit_char = base + {3'd0, d} - 7'd10;
        end else begin
            digit_char = CH_ZERO + {3'd0, d};
        end
    endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Formats one 32-bit integer per input item as printf-style text (signed or unsigned
// decimal, lower or upper hex) with field width, left-align and zero-pad, and streams
// the characters out one per output item, the final one flagged by last. Decimal items
// run a shift-and-add-3 binary-to-BCD converter, one value bit per cycle; hex items
// skip it. Leading zero digits are then shifted out one digit per cycle (up to 9 for
// decimal, up to 7 for hex), the field is set up, and characters leave at one per
// cycle while the sink is ready. Each item yields 1 to 63 characters. A new item is
// accepted once the last character of the previous one sits in the output register.
module integer_to_ascii_formatter (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  itoa_fmt_pkg::t_in_item  i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output itoa_fmt_pkg::t_out_item o_out_data
);
    import itoa_fmt_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CONV  = 3'd1;
    localparam logic [2:0] ST_NORM  = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    // control
    logic [2:0]           r_state, n_state;
    logic                 r_ovalid, n_ovalid;
    logic [BIT_CNT_W-1:0] r_bitcnt, n_bitcnt;
    logic [NDIG_W-1:0]    r_ndig, n_ndig;
    logic [FWIDTH_W-1:0]  r_left, n_left;
    logic [FWIDTH_W-1:0]  r_lpad, n_lpad;
    logic [FWIDTH_W-1:0]  r_rpad, n_rpad;
    logic                 r_mf, n_mf;
    logic                 r_im, n_im;

    // payload
    logic [VALUE_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic                 r_neg, n_neg;
    logic                 r_upper, n_upper;
    logic [FWIDTH_W-1:0]  r_fw, n_fw;
    logic                 r_lalign, n_lalign;
    logic                 r_zp, n_zp;
    t_out_item            r_out, n_out;

    logic                 w_in_acc;
    logic                 w_load;
    logic                 w_neg_in;
    logic [VALUE_W-1:0]   w_mag;
    logic [BCD_W-1:0]     w_adj;
    logic                 w_mf;
    logic [FWIDTH_W-1:0]  w_weff;
    logic [FWIDTH_W-1:0]  w_len;
    logic [FWIDTH_W-1:0]  w_padn;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_load      = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign w_neg_in = (i_in_data.kind == KIND_SDEC) && i_in_data.value[VALUE_W-1];
    assign w_mag    = w_neg_in ? (~i_in_data.value + 1'b1) : i_in_data.value;

    // add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? (r_bcd[4*i +: 4] + 4'd3)
                                                          : r_bcd[4*i +: 4];
        end
    end

    // field setup: a minus ahead of zero padding eats one width position
    assign w_mf   = r_neg && (r_fw != '0) && r_zp;
    assign w_weff = r_fw - {{(FWIDTH_W-1){1'b0}}, w_mf};
    assign w_len  = {{(FWIDTH_W-NDIG_W){1'b0}}, r_ndig}
                  + {{(FWIDTH_W-1){1'b0}}, (r_neg && !w_mf)};
    assign w_padn = (w_weff > w_len) ? (w_weff - w_len) : '0;

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_bitcnt = r_bitcnt;
        n_ndig   = r_ndig;
        n_left   = r_left;
        n_lpad   = r_lpad;
        n_rpad   = r_rpad;
        n_mf     = r_mf;
        n_im     = r_im;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_neg    = r_neg;
        n_upper  = r_upper;
        n_fw     = r_fw;
        n_lalign = r_lalign;
        n_zp     = r_zp;
        n_out    = r_out;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_neg    = w_neg_in;
                    n_upper  = (i_in_data.kind == KIND_UHEX);
                    n_fw     = i_in_data.field_width;
                    n_lalign = i_in_data.left_align;
                    n_zp     = i_in_data.zero_pad;
                    if (i_in_data.kind == KIND_LHEX || i_in_data.kind == KIND_UHEX) begin
                        n_bcd   = {w_mag, {(BCD_W-VALUE_W){1'b0}}};
                        n_ndig  = NDIG_W'(HEX_DIGITS);
                        n_state = ST_NORM;
                    end else begin
                        n_bin    = w_mag;
                        n_bcd    = '0;
                        n_bitcnt = '1;
                        n_state  = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_bcd    = {w_adj[BCD_W-2:0], r_bin[VALUE_W-1]};
                n_bin    = {r_bin[VALUE_W-2:0], 1'b0};
                n_bitcnt = r_bitcnt - 1'b1;
                if (r_bitcnt == '0) begin
                    n_ndig  = NDIG_W'(DEC_DIGITS);
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                // drop leading zero digits, keep at least one
                if (r_ndig > NDIG_W'(1) && r_bcd[BCD_W-1 -: 4] == 4'd0) begin
                    n_bcd  = {r_bcd[BCD_W-5:0], 4'd0};
                    n_ndig = r_ndig - 1'b1;
                end else begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_mf    = w_mf;
                n_im    = r_neg && !w_mf;
                n_lpad  = r_lalign ? '0 : w_padn;
                n_rpad  = r_lalign ? w_padn : '0;
                n_left  = {{(FWIDTH_W-1){1'b0}}, w_mf} + w_padn + w_len;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_load) begin
                    n_ovalid   = 1'b1;
                    n_out.last = (r_left == FWIDTH_W'(1));
                    n_left     = r_left - 1'b1;
                    if (r_mf) begin
                        n_out.char_out = CH_MINUS;
                        n_mf           = 1'b0;
                    end else if (r_lpad != '0) begin
                        n_out.char_out = r_zp ? CH_ZERO : CH_SPACE;
                        n_lpad         = r_lpad - 1'b1;
                    end else if (r_im) begin
                        n_out.char_out = CH_MINUS;
                        n_im           = 1'b0;
                    end else if (r_ndig != '0) begin
                        n_out.char_out = digit_char(r_bcd[BCD_W-1 -: 4], r_upper);
                        n_bcd          = {r_bcd[BCD_W-5:0], 4'd0};
                        n_ndig         = r_ndig - 1'b1;
                    end else begin
                        n_out.char_out = r_zp ? CH_ZERO : CH_SPACE;
                        n_rpad         = r_rpad - 1'b1;
                    end
                    if (r_left == FWIDTH_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_bitcnt <= '0;
            r_ndig   <= '0;
            r_left   <= '0;
            r_lpad   <= '0;
            r_rpad   <= '0;
            r_mf     <= 1'b0;
            r_im     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_bitcnt <= n_bitcnt;
            r_ndig   <= n_ndig;
            r_left   <= n_left;
            r_lpad   <= n_lpad;
            r_rpad   <= n_rpad;
            r_mf     <= n_mf;
            r_im     <= n_im;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin    <= n_bin;
        r_bcd    <= n_bcd;
        r_neg    <= n_neg;
        r_upper  <= n_upper;
        r_fw     <= n_fw;
        r_lalign <= n_lalign;
        r_zp     <= n_zp;
        r_out    <= n_out;
    end

    `ASSERT_CLK(a_emit_has_chars, (r_state == ST_EMIT) |-> (r_left != '0),
                "emit with no characters left")
    `ASSERT_CLK(a_norm_done, (r_state == ST_SETUP) |-> (r_ndig != '0 &&
                (r_ndig == NDIG_W'(1) || r_bcd[BCD_W-1 -: 4] != 4'd0)), "digits not normalized")
    `ASSERT_CLK(a_last_closes, (r_state == ST_EMIT && w_load && r_left == FWIDTH_W'(1)) |=>
                (r_state == ST_IDLE && o_out_valid && o_out_data.last), "final character not flagged")
    `ASSERT_ALWAYS(a_reset_idle, (!i_rst_n) |=> (r_state == ST_IDLE && !o_out_valid),
                   "reset did not clear control")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import itoa_fmt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 45;
    localparam int SQUEEZE_ITEMS = 20;
    localparam int NUM_DIRECTED = 23;

    typedef struct {
        t_in_item num;
        string    text;   // empty: take the predictor's text
    } t_dir_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_data = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_data;

    t_out_item expected_chars[$];
    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        hold_reqs = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        errors = 0;
    int        cycles = 0;
    int        numbers_sent = 0;
    int        chars_seen = 0;

    t_dir_row dir_rows [0:NUM_DIRECTED-1] = '{
        '{'{KIND_SDEC, 32'h0000_0000, 6'd0, 1'b0, 1'b0}, "0"},
        '{'{KIND_SDEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0}, "-2147483648"},
        '{'{KIND_SDEC, 32'h7FFF_FFFF, 6'd0, 1'b0, 1'b0}, "2147483647"},
        '{'{KIND_UDEC, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0}, "4294967295"},
        '{'{KIND_LHEX, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0}, "ffffffff"},
        '{'{KIND_UHEX, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b0}, "FFFFFFFF"},
        '{'{KIND_LHEX, 32'hDEAD_BEEF, 6'd0, 1'b0, 1'b0}, "deadbeef"},
        '{'{KIND_UHEX, 32'h0ABC_DEF0, 6'd0, 1'b0, 1'b0}, "ABCDEF0"},
        '{'{KIND_SDEC, 32'hFFFF_FFFB, 6'd4, 1'b0, 1'b1}, "-005"},
        '{'{KIND_SDEC, 32'hFFFF_FFFB, 6'd4, 1'b0, 1'b0}, "  -5"},
        '{'{KIND_SDEC, 32'hFFFF_FFFB, 6'd4, 1'b1, 1'b0}, "-5  "},
        '{'{KIND_SDEC, 32'hFFFF_FFFB, 6'd4, 1'b1, 1'b1}, "-500"},
        '{'{KIND_UDEC, 32'd42,        6'd1, 1'b0, 1'b0}, "42"},
        '{'{KIND_UDEC, 32'd0,         6'd63, 1'b0, 1'b1}, ""},
        '{'{KIND_UHEX, 32'h0000_001F, 6'd63, 1'b1, 1'b0}, ""},
        '{'{KIND_SDEC, 32'h8000_0000, 6'd63, 1'b0, 1'b1}, ""},
        '{'{KIND_SDEC, 32'hFFFF_FFFF, 6'd1, 1'b0, 1'b1}, "-1"},
        '{'{KIND_UDEC, 32'h8000_0000, 6'd0, 1'b0, 1'b0}, "2147483648"},
        '{'{KIND_LHEX, 32'h0000_0000, 6'd3, 1'b0, 1'b1}, "000"},
        '{'{KIND_SDEC, 32'd123,       6'd6, 1'b1, 1'b1}, "123000"},
        '{'{KIND_UDEC, 32'd7,         6'd0, 1'b1, 1'b1}, "7"},
        '{'{KIND_UHEX, 32'h0000_000F, 6'd2, 1'b0, 1'b0}, " F"},
        '{'{KIND_SDEC, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b1}, "-1"}
    };

    integer_to_ascii_formatter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Appends the printf-style text of one number to the expected characters.
    function automatic void predict_text(input t_in_item num);
        t_out_item         chars[$];
        logic [CHAR_W-1:0] digits[$];
        logic [CHAR_W-1:0] letter;
        logic [CHAR_W-1:0] padc;
        logic [31:0]       mag;
        logic [31:0]       base;
        logic [31:0]       d;
        logic              neg;
        int                w;
        int                padn;
        neg = (num.kind == KIND_SDEC) && num.value[31];
        mag = neg ? (32'd0 - num.value) : num.value;
        base = (num.kind == KIND_LHEX || num.kind == KIND_UHEX) ? 32'd16 : 32'd10;
        letter = (num.kind == KIND_UHEX) ? CH_UA : CH_LA;
        padc = num.zero_pad ? CH_ZERO : CH_SPACE;
        w = num.field_width;
        do begin
            d = mag % base;
            digits.push_front((d >= 32'd10) ? letter + d[CHAR_W-1:0] - 7'd10
                                             : CH_ZERO + d[CHAR_W-1:0]);
            mag = mag / base;
        end while (mag != 32'd0);
        // zero-padded negative: sign leads, then the zeros
        if (neg) begin
            if (w != 0 && num.zero_pad) begin
                chars.push_back('{CH_MINUS, 1'b0});
                w--;
            end else begin
                digits.push_front(CH_MINUS);
            end
        end
        padn = (w > digits.size()) ? w - digits.size() : 0;
        if (!num.left_align) begin
            repeat (padn) chars.push_back('{padc, 1'b0});
        end
        foreach (digits[i]) chars.push_back('{digits[i], 1'b0});
        if (num.left_align) begin
            repeat (padn) chars.push_back('{padc, 1'b0});
        end
        chars[chars.size()-1].last = 1'b1;
        foreach (chars[i]) expected_chars.push_back(chars[i]);
    endfunction

    function automatic t_in_item random_number();
        t_in_item num;
        num.kind = 2'($urandom_range(3));
        case ($urandom_range(5))
            0: num.value = $urandom_range(99);
            1: num.value = 32'd0 - $urandom_range(1, 99);
            2: num.value = 32'h8000_0000 ^ $urandom_range(3);
            3: num.value = $urandom >> $urandom_range(31);
            default: num.value = $urandom;
        endcase
        // mostly short fields, now and then a long one
        num.field_width = ($urandom_range(8) == 0) ? 6'($urandom_range(63))
                                                   : 6'($urandom_range(12));
        num.left_align = 1'($urandom_range(1));
        num.zero_pad = 1'($urandom_range(1));
        return num;
    endfunction

    // Offers one number and waits for it to be taken; text empty means predict it.
    task automatic offer_number(input t_in_item num, input string text);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= num;
        do @(posedge i_clk); while (!o_in_ready);
        numbers_sent++;
        if (text.len() == 0) begin
            predict_text(num);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                expected_chars.push_back('{CHAR_W'(text[i]), i == text.len() - 1});
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            chars_seen++;
            if (expected_chars.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected char %h last %b", o_out_data.char_out, o_out_data.last);
                end
            end else begin
                want = expected_chars.pop_front();
                if (o_out_data.char_out !== want.char_out || o_out_data.last !== want.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("char %0d mismatch: expected char %h last %b, got char %h last %b",
                                 chars_seen, want.char_out, want.last,
                                 o_out_data.char_out, o_out_data.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d chars still expected",
                     cycles, expected_chars.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int idle_by_phase[4];
        int stall_by_phase[4];
        idle_by_phase = '{0, 72, 0, 10};
        stall_by_phase = '{0, 0, 72, 10};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) offer_number(dir_rows[r].num, dir_rows[r].text);

        for (int p = 0; p < 4; p++) begin
            src_idle_pct = idle_by_phase[p];
            sink_stall_pct = stall_by_phase[p];
            repeat (PHASE_ITEMS) offer_number(random_number(), "");
        end

        // long output stall with a busy sender, so the block backs up its input
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_reqs++;
        repeat (SQUEEZE_ITEMS) offer_number(random_number(), "");
        i_in_valid <= 1'b0;

        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Formatted %0d numbers (%0d from the directed table) into %0d chars,",
                 numbers_sent, NUM_DIRECTED, chars_seen);
        $display("over four source/sink pacing phases and one %0d-cycle sink hold.", HOLD_CYCLES);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/itoa_fmt_pkg.sv
rtl/integer_to_ascii_formatter.sv
tb/tb.sv
